### rtl/kwm_pkg.sv
// kwm_pkg: shared types and codes for the k-way sorted merge block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package kwm_pkg;

  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 2;
  localparam int LIDX_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TAKE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic do_append;
    logic do_clear;
    logic do_nop;
    logic take_start;
    logic scan_issue;
    logic finish;
  } kwm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } kwm_stat_t;

endpackage

`default_nettype wire

### rtl/kwm_ram.sv
// kwm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/kwm_ctrl.sv
// kwm_ctrl: sequencing state machine for the k-way sorted merge.
// Depends on kwm_pkg; drives the datapath through kwm_cmd_t.
`default_nettype none

module kwm_ctrl
  import kwm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire kwm_stat_t         stat,
  output kwm_cmd_t               cmd,
  output logic                   busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_func == FN_TAKE) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_func == FN_APPEND) begin
            cmd.do_append = 1'b1;
          end else if (in_func == FN_TAKE) begin
            cmd.take_start = 1'b1;
          end else if (in_func == FN_CLEAR) begin
            cmd.do_clear = 1'b1;
          end else begin
            cmd.do_nop = 1'b1;
          end
        end
      end
      S_SCAN:  cmd.scan_issue = 1'b1;
      S_LAST:  ;  // last head read is compared in the datapath
      S_DONE:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/kwm_dp.sv
// kwm_dp: per-list counters, element RAM, head scan compare and result registers.
// Depends on kwm_pkg and kwm_ram; commanded by kwm_ctrl.
`default_nettype none

module kwm_dp
  import kwm_pkg::*;
#(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64,
  parameter int LIST_W     = 3,
  parameter int CNT_W      = 7,
  parameter int ADDR_W     = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kwm_cmd_t           cmd,
  output kwm_stat_t               stat,
  input  wire logic [LIDX_W-1:0]  in_list_index,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_strobe,
  output logic [VALUE_W-1:0]      out_value,
  output logic [LIDX_W-1:0]       out_source_list,
  output logic [STAT_W-1:0]       out_status
);

  function automatic logic [ADDR_W-1:0] list_base(input logic [LIST_W-1:0] sel);
    list_base = ADDR_W'(sel) * ADDR_W'(LIST_DEPTH);
  endfunction

  logic [CNT_W-1:0] fill_r [NUM_LISTS];
  logic [CNT_W-1:0] fill_nxt [NUM_LISTS];
  logic [CNT_W-1:0] take_r [NUM_LISTS];
  logic [CNT_W-1:0] take_nxt [NUM_LISTS];

  logic [LIST_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [LIST_W-1:0]        rd_idx_r;
  logic                     found_r, found_nxt;
  logic [LIST_W-1:0]        best_idx_r, best_idx_nxt;
  logic signed [VALUE_W-1:0] best_val_r, best_val_nxt;

  logic                     strobe_r, strobe_nxt;
  logic [VALUE_W-1:0]       res_val_r, res_val_nxt;
  logic [LIST_W-1:0]        res_src_r, res_src_nxt;
  logic [STAT_W-1:0]        res_st_r, res_st_nxt;

  // append side
  logic [LIST_W+LIDX_W-1:0] app_ext;
  logic [LIST_W-1:0]        app_sel;
  logic                     app_in_range;
  logic                     app_ok;
  logic [ADDR_W-1:0]        wr_addr;

  // scan side
  logic                     scan_nonempty;
  logic [ADDR_W-1:0]        rd_addr;
  logic [VALUE_W-1:0]       rd_data;
  logic                     cand_win;

  logic [LIST_W+LIDX_W-1:0] src_ext;

  assign app_ext      = {{LIST_W{1'b0}}, in_list_index};
  assign app_sel      = app_ext[LIST_W-1:0];
  assign app_in_range = int'(in_list_index) < NUM_LISTS;
  assign app_ok       = app_in_range && (fill_r[app_sel] < CNT_W'(LIST_DEPTH));
  assign wr_addr      = list_base(app_sel) + ADDR_W'(fill_r[app_sel]);

  assign scan_nonempty  = take_r[scan_idx_r] < fill_r[scan_idx_r];
  assign rd_addr        = list_base(scan_idx_r) + ADDR_W'(take_r[scan_idx_r]);
  assign stat.scan_last = scan_idx_r == LIST_W'(NUM_LISTS - 1);

  // strict less keeps the lower list index on equal heads
  assign cand_win = rd_vld_r && (!found_r || ($signed(rd_data) < best_val_r));

  kwm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NUM_LISTS * LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_append && app_ok),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    fill_nxt = fill_r;
    take_nxt = take_r;
    if (cmd.do_clear) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_nxt[i] = '0;
        take_nxt[i] = '0;
      end
    end else if (cmd.do_append && app_ok) begin
      fill_nxt[app_sel] = fill_r[app_sel] + 1'b1;
    end else if (cmd.finish && found_r) begin
      take_nxt[best_idx_r] = take_r[best_idx_r] + 1'b1;
    end
  end

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    if (cmd.take_start) begin
      scan_idx_nxt = '0;
      found_nxt    = 1'b0;
    end else if (cmd.scan_issue) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
      rd_vld_nxt   = scan_nonempty;
    end
    if (cand_win) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_val_nxt = $signed(rd_data);
    end
  end

  always_comb begin
    strobe_nxt  = cmd.do_append || cmd.do_clear || cmd.do_nop || cmd.finish;
    res_val_nxt = '0;
    res_src_nxt = '0;
    res_st_nxt  = ST_OK;
    if (cmd.do_append && !app_ok) begin
      res_st_nxt = ST_DROPPED;
    end else if (cmd.finish) begin
      if (found_r) begin
        res_val_nxt = best_val_r;
        res_src_nxt = best_idx_r;
      end else begin
        res_st_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_r[i] <= '0;
        take_r[i] <= '0;
      end
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      take_r   <= take_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= scan_idx_r;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    res_val_r  <= res_val_nxt;
    res_src_r  <= res_src_nxt;
    res_st_r   <= res_st_nxt;
  end

  // source port keeps the low three bits of the list number
  assign src_ext         = {{LIDX_W{1'b0}}, res_src_r};
  assign out_strobe      = strobe_r;
  assign out_value       = res_val_r;
  assign out_source_list = src_ext[LIDX_W-1:0];
  assign out_status      = res_st_r;

endmodule

`default_nettype wire

### rtl/k_way_sorted_merge.sv
// k_way_sorted_merge: top level, controller plus datapath of the k-way merge.
// Depends on kwm_pkg, kwm_ctrl, kwm_dp (and kwm_ram below it).
//
//  channel   ports                                        transfer when
//  input     in_func, in_list_index, in_value            start && !busy
//  result    out_value, out_source_list, out_status      out_strobe
//
// For append, clear and unused codes the result strobes in the cycle after the
// accept, and a new item may be accepted in that same cycle.
// A take scans every list head through the element RAM, one list per cycle
// with registered read data; the sequencer then steps through S_LAST and S_DONE,
// strobes the result back in idle and accepts no new item until then.
// Synchronous active-low reset empties all lists; the RAM is not cleared.
// The receiver cannot stall: each result is on the ports for one cycle only.
`default_nettype none

module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [LIDX_W-1:0]  in_list_index,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_strobe,
  output logic [VALUE_W-1:0]      out_value,
  output logic [LIDX_W-1:0]       out_source_list,
  output logic [STAT_W-1:0]       out_status
);

  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_LISTS * LIST_DEPTH);

  kwm_cmd_t  cmd;
  kwm_stat_t stat;

  kwm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  kwm_dp #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .LIST_W     (LIST_W),
    .CNT_W      (CNT_W),
    .ADDR_W     (ADDR_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_list_index   (in_list_index),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_value       (out_value),
    .out_source_list (out_source_list),
    .out_status      (out_status)
  );

  // results only ever appear once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FN_TAKE) |=> out_strobe)
    else $error("non-take transfer without result in next cycle");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FN_TAKE) |=> (busy && !out_strobe))
    else $error("take transfer did not start a scan");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_value == '0 && out_source_list == '0))
    else $error("nonzero payload on error status");

endmodule

`default_nettype wire
